/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked property that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/i2r_pkg.sv */
package i2r_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [11:0] MAX_VALUE = 12'd3999;

    // status codes of a result item
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // ASCII letters
    localparam logic [6:0] SYM_NONE = 7'h00;
    localparam logic [6:0] SYM_I    = 7'h49;
    localparam logic [6:0] SYM_V    = 7'h56;
    localparam logic [6:0] SYM_X    = 7'h58;
    localparam logic [6:0] SYM_L    = 7'h4C;
    localparam logic [6:0] SYM_C    = 7'h43;
    localparam logic [6:0] SYM_D    = 7'h44;
    localparam logic [6:0] SYM_M    = 7'h4D;

    // places of a decimal digit
    localparam logic [1:0] PLACE_ONES  = 2'd0;
    localparam logic [1:0] PLACE_TENS  = 2'd1;
    localparam logic [1:0] PLACE_HUNDS = 2'd2;
    localparam logic [1:0] PLACE_THOUS = 2'd3;

    typedef enum logic [1:0] {
        KIND_ONE,
        KIND_FIVE,
        KIND_TEN
    } t_kind;

    // one classified number, as handed from front to back
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] thous;
        logic [3:0] hunds;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_entry;

    // letter count of a digit, minus one
    function automatic logic [1:0] digit_len_m1(input logic [3:0] d);
        logic [1:0] len;
        unique case (d)
            4'd2, 4'd4, 4'd6, 4'd9: len = 2'd1;
            4'd3, 4'd7:             len = 2'd2;
            4'd8:                   len = 2'd3;
            default:                len = 2'd0;
        endcase
        return len;
    endfunction

    function automatic t_kind letter_kind(input logic [3:0] d, input logic [1:0] pos);
        t_kind k;
        priority if (d == 4'd9) begin
            k = (pos == 2'd0) ? KIND_ONE : KIND_TEN;
        end else if (d >= 4'd5) begin
            k = (pos == 2'd0) ? KIND_FIVE : KIND_ONE;
        end else if (d == 4'd4) begin
            k = (pos == 2'd0) ? KIND_ONE : KIND_FIVE;
        end else begin
            k = KIND_ONE;
        end
        return k;
    endfunction

    function automatic logic [6:0] place_symbol(input logic [1:0] place, input t_kind k);
        logic [6:0] s;
        s = SYM_NONE;
        unique case (place)
            PLACE_ONES: begin
                unique case (k)
                    KIND_ONE:  s = SYM_I;
                    KIND_FIVE: s = SYM_V;
                    KIND_TEN:  s = SYM_X;
                    default:   s = SYM_NONE;
                endcase
            end
            PLACE_TENS: begin
                unique case (k)
                    KIND_ONE:  s = SYM_X;
                    KIND_FIVE: s = SYM_L;
                    KIND_TEN:  s = SYM_C;
                    default:   s = SYM_NONE;
                endcase
            end
            PLACE_HUNDS: begin
                unique case (k)
                    KIND_ONE:  s = SYM_C;
                    KIND_FIVE: s = SYM_D;
                    KIND_TEN:  s = SYM_M;
                    default:   s = SYM_NONE;
                endcase
            end
            PLACE_THOUS: begin
                s = (k == KIND_ONE) ? SYM_M : SYM_NONE;
            end
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

    // highest place whose bit is set in the mask
    function automatic logic [1:0] top_place(input logic [3:0] mask);
        logic [1:0] p;
        priority if (mask[3]) begin
            p = PLACE_THOUS;
        end else if (mask[2]) begin
            p = PLACE_HUNDS;
        end else if (mask[1]) begin
            p = PLACE_TENS;
        end else begin
            p = PLACE_ONES;
        end
        return p;
    endfunction

endpackage

/* rtl/i2r_front.sv */
module i2r_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [11:0]        i_number,
    output logic               o_push,
    input  logic               i_full,
    output i2r_pkg::t_entry    o_entry
);

    logic       r_a_valid;
    logic [1:0] r_a_status;
    logic [1:0] r_a_thous;
    logic [9:0] r_a_rem;

    logic [1:0]  n_a_status;
    logic [1:0]  n_a_thous;
    logic [9:0]  n_a_rem;
    logic [11:0] thous_sub;

    logic [3:0] hunds;
    logic [6:0] rem_tens;
    logic [3:0] tens;
    logic [3:0] ones;

    // stage A: classify, split off thousands
    always_comb begin
        priority if (i_number == 12'd0) begin
            n_a_status = i2r_pkg::STATUS_EMPTY;
        end else if (i_number > i2r_pkg::MAX_VALUE) begin
            n_a_status = i2r_pkg::STATUS_RANGE;
        end else begin
            n_a_status = i2r_pkg::STATUS_OK;
        end
        priority if (i_number >= 12'd3000) begin
            n_a_thous = 2'd3;
        end else if (i_number >= 12'd2000) begin
            n_a_thous = 2'd2;
        end else if (i_number >= 12'd1000) begin
            n_a_thous = 2'd1;
        end else begin
            n_a_thous = 2'd0;
        end
        thous_sub = i_number - 12'(n_a_thous) * 12'd1000;
        n_a_rem   = thous_sub[9:0];
    end

    assign o_ready = !r_a_valid || !i_full;
    assign o_push  = r_a_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_a_status <= n_a_status;
            r_a_thous  <= n_a_thous;
            r_a_rem    <= n_a_rem;
        end
    end

    // stage B: hundreds, tens and ones out of the remainder
    always_comb begin
        hunds = 4'd0;
        for (int k = 9; k >= 1; k--) begin
            if (hunds == 4'd0 && r_a_rem >= 10'(k * 100)) begin
                hunds = 4'(k);
            end
        end
        rem_tens = 7'(r_a_rem - 10'(hunds) * 10'd100);
        tens = 4'd0;
        for (int k = 9; k >= 1; k--) begin
            if (tens == 4'd0 && rem_tens >= 7'(k * 10)) begin
                tens = 4'(k);
            end
        end
        ones = 4'(rem_tens - 7'(tens) * 7'd10);
    end

    assign o_entry = '{status: r_a_status, thous: r_a_thous, hunds: hunds,
                       tens: tens, ones: ones};

endmodule

/* rtl/i2r_queue.sv */
module i2r_queue #(
    parameter int Depth = i2r_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2r_pkg::t_entry  i_entry,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output i2r_pkg::t_entry  o_entry
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    i2r_pkg::t_entry r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/i2r_back.sv */
module i2r_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  i2r_pkg::t_entry  i_q_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [6:0]       o_symbol,
    output logic             o_last,
    output logic [1:0]       o_status
);

    logic            r_busy;
    i2r_pkg::t_entry r_entry;
    logic [1:0]      r_place;
    logic [1:0]      r_pos;
    logic            r_out_valid;
    logic [6:0]      r_symbol;
    logic            r_last;
    logic [1:0]      r_status;

    logic       advance;
    logic       emit;
    logic [3:0] digit;
    logic [3:0] nz_mask;
    logic [3:0] q_nz_mask;
    logic [3:0] lower_mask;
    logic       has_next;
    logic       digit_done;
    logic       special;
    logic       n_last;
    logic [6:0] n_symbol;

    always_comb begin
        unique case (r_place)
            i2r_pkg::PLACE_ONES:  digit = r_entry.ones;
            i2r_pkg::PLACE_TENS:  digit = r_entry.tens;
            i2r_pkg::PLACE_HUNDS: digit = r_entry.hunds;
            i2r_pkg::PLACE_THOUS: digit = {2'b00, r_entry.thous};
            default:              digit = r_entry.ones;
        endcase
        nz_mask    = {r_entry.thous != 2'd0, r_entry.hunds != 4'd0,
                      r_entry.tens != 4'd0, r_entry.ones != 4'd0};
        q_nz_mask  = {i_q_entry.thous != 2'd0, i_q_entry.hunds != 4'd0,
                      i_q_entry.tens != 4'd0, i_q_entry.ones != 4'd0};
        lower_mask = nz_mask & ((4'b0001 << r_place) - 4'b0001);
        has_next   = (lower_mask != 4'b0000);
        digit_done = (r_pos == i2r_pkg::digit_len_m1(digit));
        special    = (r_entry.status != i2r_pkg::STATUS_OK);
        n_last     = special || (digit_done && !has_next);
        n_symbol   = special ? i2r_pkg::SYM_NONE
                   : i2r_pkg::place_symbol(r_place, i2r_pkg::letter_kind(digit, r_pos));
    end

    assign advance = !r_out_valid || i_ready;
    assign emit    = r_busy && advance;
    // take the next item as the current one gives its last letter
    assign o_pop   = i_q_valid && (!r_busy || (emit && n_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && n_last) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_busy;
            end
        end
        if (o_pop) begin
            r_entry <= i_q_entry;
            r_place <= i2r_pkg::top_place(q_nz_mask);
            r_pos   <= 2'd0;
        end else if (emit && !n_last) begin
            if (digit_done) begin
                r_place <= i2r_pkg::top_place(lower_mask);
                r_pos   <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
        if (emit) begin
            r_symbol <= n_symbol;
            r_last   <= n_last;
            r_status <= r_entry.status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;
    assign o_status = r_status;

endmodule

/* rtl/integer_to_roman_encoder.sv */
// Channel   Dir  Handshake          Payload
// input     in   i_valid / o_ready  i_number[11:0]
// output    out  o_valid / i_ready  o_symbol[6:0], o_last, o_status[1:0]
//
// One letter leaves per cycle unless the output stalls or the queue is empty;
// a number gives as many letters as its numeral has (1 to 15), or one
// letterless item for zero and for values above 3999. The back-end letter
// sequencer sets that rate; a number passes front stage A, the queue and the
// back's entry register before its first letter is registered and offered.
// Reset is synchronous and active low and clears all control state.
// Either side may stall; the queue lets the front keep taking items.

`include "assert_macros.svh"

module integer_to_roman_encoder #(
    parameter int QueueDepth = i2r_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_symbol,
    output logic        o_last,
    output logic [1:0]  o_status
);

    // front to queue
    logic            push;
    logic            q_full;
    i2r_pkg::t_entry push_entry;

    // queue to back
    logic            q_valid;
    logic            pop;
    i2r_pkg::t_entry head_entry;

    // output item classes for the checks at the end
    logic            out_flag;
    logic            out_ok;
    logic            out_none;
    logic            out_lone;

    // Front: classify the number and split it into decimal digits.
    i2r_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_number (i_number),
        .o_push   (push),
        .i_full   (q_full),
        .o_entry  (push_entry)
    );

    // Queue: decouple the digit split from the letter sequencer.
    i2r_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_entry (head_entry)
    );

    // Back: walk the digits from thousands down, one letter per cycle unless the
    // output stalls, skipping zero digits without a gap, into a registered output.
    i2r_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (head_entry),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_symbol  (o_symbol),
        .o_last    (o_last),
        .o_status  (o_status)
    );

    assign out_flag = o_valid && (o_status != i2r_pkg::STATUS_OK);
    assign out_ok   = o_valid && (o_status == i2r_pkg::STATUS_OK);
    assign out_none = (o_symbol == i2r_pkg::SYM_NONE);
    assign out_lone = o_last && out_none;

    // A flagged result is always a single letterless item.
    `ASSERT_CLK(a_flag_single, i_clk, i_rst_n, out_flag |-> out_lone, "flagged item not lone")
    // A normal result always carries a letter.
    `ASSERT_CLK(a_ok_letter, i_clk, i_rst_n, out_ok |-> !out_none, "no symbol on letter item")
    // Nothing is offered right after reset.
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

/* verif/tb_top.sv */
module tb_top;
    import i2r_pkg::*;

    // cycles with no item moving on either side before the run is called hung
    localparam int HANG_LIMIT  = 2000;
    // quiet cycles after the last letter, to catch anything extra
    localparam int TAIL_CYCLES = 20;

    // one expected letter of a numeral
    typedef struct packed {
        logic [6:0] symbol;
        logic       last;
        logic [1:0] status;
    } t_letter;

    // one row of the directed table; spelled rows carry their numeral
    typedef struct {
        logic [11:0] number;
        bit          spelled;
        string       numeral;
        logic [1:0]  status;
    } t_row;

    // one, five and ten letters per place, ones first
    localparam logic [6:0] ONE_SYM  [4] = '{SYM_I, SYM_X, SYM_C, SYM_M};
    localparam logic [6:0] FIVE_SYM [4] = '{SYM_V, SYM_L, SYM_D, SYM_NONE};
    localparam logic [6:0] TEN_SYM  [4] = '{SYM_X, SYM_C, SYM_M, SYM_NONE};
    localparam int         DECADE   [4] = '{1, 10, 100, 1000};

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic [11:0] i_number = '0;
    logic        i_ready  = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [6:0]  o_symbol;
    logic        o_last;
    logic [1:0]  o_status;

    // side band that travels with the number being offered
    bit          item_spelled = 1'b0;
    string       item_numeral = "";
    logic [1:0]  item_status  = STATUS_OK;

    t_letter     numeral_q[$];
    int          mismatches    = 0;
    int          quiet_cycles  = 0;
    int          send_idle_pct = 18;
    int          take_idle_pct = 82;
    t_row        directed_rows[25];

    integer_to_roman_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_number (i_number),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_symbol (o_symbol),
        .o_last   (o_last),
        .o_status (o_status)
    );

    always #1 i_clk = ~i_clk;

    // Stall the output side at the rate of the current phase.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= take_idle_pct);
    end

    // Spell one number and queue its letters; zero and values above the
    // top of the range give a single flagged letter with no symbol.
    task automatic spell_numeral(input logic [11:0] value);
        logic [6:0] run[$];
        int         rest;
        int         digit;
        int         place;
        int         k;
        if (value == 12'd0) begin
            numeral_q.push_back('{SYM_NONE, 1'b1, STATUS_EMPTY});
        end else if (value > MAX_VALUE) begin
            numeral_q.push_back('{SYM_NONE, 1'b1, STATUS_RANGE});
        end else begin
            rest = int'(value);
            for (place = 3; place >= 0; place--) begin
                digit = rest / DECADE[place];
                rest  = rest % DECADE[place];
                case (digit)
                    4: begin
                        run.push_back(ONE_SYM[place]);
                        run.push_back(FIVE_SYM[place]);
                    end
                    9: begin
                        run.push_back(ONE_SYM[place]);
                        run.push_back(TEN_SYM[place]);
                    end
                    default: begin
                        if (digit >= 5) begin
                            run.push_back(FIVE_SYM[place]);
                            digit -= 5;
                        end
                        repeat (digit) run.push_back(ONE_SYM[place]);
                    end
                endcase
            end
            for (k = 0; k < run.size(); k++) begin
                numeral_q.push_back('{run[k], k == run.size() - 1, STATUS_OK});
            end
        end
    endtask

    // Watch both channels at every edge: queue letters for each number taken,
    // check each letter handed out, and call the run hung if nothing moves.
    always @(posedge i_clk) begin
        t_letter want;
        byte     ch;
        int      k;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (numeral_q.size() == 0) begin
                    $error("unexpected item: symbol %h last %b status %0d",
                           o_symbol, o_last, o_status);
                    mismatches++;
                end else begin
                    want = numeral_q.pop_front();
                    if (o_symbol !== want.symbol) begin
                        $error("symbol: expected %h, got %h", want.symbol, o_symbol);
                        mismatches++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, o_last);
                        mismatches++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                end
            end

            if (i_valid && o_ready) begin
                if (!item_spelled) begin
                    spell_numeral(i_number);
                end else if (item_status != STATUS_OK) begin
                    numeral_q.push_back('{SYM_NONE, 1'b1, item_status});
                end else begin
                    for (k = 0; k < item_numeral.len(); k++) begin
                        ch = item_numeral[k];
                        numeral_q.push_back('{ch[6:0], k == item_numeral.len() - 1,
                                              STATUS_OK});
                    end
                end
            end

            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Offer one number after a random gap and hold it until it is taken.
    task automatic offer_number(input logic [11:0] value, input bit spelled,
                                input string numeral, input logic [1:0] status);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_number     <= value;
        item_spelled <= spelled;
        item_numeral <= numeral;
        item_status  <= status;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and hold off until every queued letter has come out.
    task automatic drain_letters();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (numeral_q.size() != 0) @(posedge i_clk);
    endtask

    // One random phase: mostly in-range numbers, plus zeros, values above
    // the range, and numbers built digit by digit to hit every digit shape.
    task automatic random_phase(input int count, input int send_pct, input int take_pct);
        int          pick;
        logic [11:0] value;
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                value = 12'd0;
            end else if (pick < 13) begin
                value = 12'($urandom_range(4095, 4000));
            end else if (pick < 30) begin
                value = 12'($urandom_range(3) * 1000 + $urandom_range(9) * 100
                      + $urandom_range(9) * 10 + $urandom_range(9));
            end else begin
                value = 12'($urandom_range(3999, 1));
            end
            offer_number(value, 1'b0, "", STATUS_OK);
        end
        drain_letters();
    endtask

    initial begin
        // Spelled rows are checked against the numeral typed here; the rest
        // go through the numeral speller.
        directed_rows = '{
            '{12'd0,    1'b1, "",                STATUS_EMPTY},
            '{12'd1,    1'b1, "I",               STATUS_OK},
            '{12'd4,    1'b1, "IV",              STATUS_OK},
            '{12'd5,    1'b1, "V",               STATUS_OK},
            '{12'd8,    1'b1, "VIII",            STATUS_OK},
            '{12'd9,    1'b1, "IX",              STATUS_OK},
            '{12'd10,   1'b1, "X",               STATUS_OK},
            '{12'd40,   1'b1, "XL",              STATUS_OK},
            '{12'd90,   1'b1, "XC",              STATUS_OK},
            '{12'd400,  1'b1, "CD",              STATUS_OK},
            '{12'd900,  1'b1, "CM",              STATUS_OK},
            '{12'd1000, 1'b1, "M",               STATUS_OK},
            '{12'd3999, 1'b1, "MMMCMXCIX",       STATUS_OK},
            '{12'd3888, 1'b1, "MMMDCCCLXXXVIII", STATUS_OK},
            '{12'd4000, 1'b1, "",                STATUS_RANGE},
            '{12'd4095, 1'b1, "",                STATUS_RANGE},
            '{12'd0,    1'b1, "",                STATUS_EMPTY},
            '{12'd4001, 1'b1, "",                STATUS_RANGE},
            '{12'd49,   1'b0, "",                STATUS_OK},
            '{12'd444,  1'b0, "",                STATUS_OK},
            '{12'd1994, 1'b0, "",                STATUS_OK},
            '{12'd2048, 1'b0, "",                STATUS_OK},
            '{12'd1365, 1'b0, "",                STATUS_OK},
            '{12'd2730, 1'b0, "",                STATUS_OK},
            '{12'd7,    1'b0, "",                STATUS_OK}
        };

        // Hold reset low from the start, then release it for good.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs with a mostly stalled output side.
        foreach (directed_rows[r]) begin
            offer_number(directed_rows[r].number, directed_rows[r].spelled,
                         directed_rows[r].numeral, directed_rows[r].status);
        end
        drain_letters();

        // Slow receiver, then slow sender, then both at full rate.
        random_phase(150, 18, 82);
        random_phase(150, 82, 18);
        random_phase(135, 0, 0);

        // Let the block sit idle to catch any letter nobody asked for.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
